// ===== src/lzwc_pkg.sv =====
package lzwc_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROOT_COUNT  = 256;
  localparam int START_WIDTH = 8;
  localparam int PAD_W       = 7;
  localparam int LANES       = 8;
  localparam int LANE_W      = 3;

  typedef struct packed {
    logic load;
    logic fin;
  } pack_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_res_t;

endpackage

// ===== src/lzwc_dict.sv =====
module lzwc_dict import lzwc_pkg::*; #(
  parameter int DICT_SIZE = 4096
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      srch_start,
  input  logic [$clog2(DICT_SIZE)+BYTE_W-1:0]       srch_key,
  input  logic [$clog2(DICT_SIZE-ROOT_COUNT):0]     srch_used,
  output srch_res_t                                 srch_res,
  output logic [$clog2(DICT_SIZE-ROOT_COUNT)-1:0]   srch_idx,
  input  logic                                      wr_en,
  input  logic [$clog2(DICT_SIZE-ROOT_COUNT)-1:0]   wr_idx,
  input  logic [$clog2(DICT_SIZE)+BYTE_W-1:0]       wr_key
);

  localparam int CODE_W    = $clog2(DICT_SIZE);
  localparam int KEY_W     = CODE_W + BYTE_W;
  localparam int ADDED_MAX = DICT_SIZE - ROOT_COUNT;
  localparam int IDX_W     = $clog2(ADDED_MAX);
  localparam int ROWS      = (ADDED_MAX + LANES - 1) / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int G_W       = ROW_W + LANE_W + 1;

  logic [LANES-1:0][KEY_W-1:0] mem [ROWS];
  logic [LANES-1:0][KEY_W-1:0] rd_data_r;

  logic              issuing_r, issuing_nxt;
  logic [ROW_W-1:0]  issue_row_r, issue_row_nxt;
  logic [ROW_W-1:0]  last_row_r, last_row_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [ROW_W-1:0]  cmp_row_r;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W:0]    used_r, used_nxt;
  srch_res_t         res_r, res_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              lane_hit;
  logic [LANE_W-1:0] hit_lane;
  logic [G_W-1:0]    glob;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ROW_W'(wr_idx >> LANE_W)][wr_idx[LANE_W-1:0]] <= wr_key;
    end
    rd_data_r <= mem[issue_row_r];
  end

  always_comb begin
    lane_hit = 1'b0;
    hit_lane = '0;
    glob     = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      glob = G_W'({cmp_row_r, LANE_W'(l)});
      if (glob < G_W'(used_r) && rd_data_r[l] == key_r) begin
        lane_hit = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
  end

  always_comb begin
    issuing_nxt   = issuing_r;
    issue_row_nxt = issue_row_r;
    last_row_nxt  = last_row_r;
    key_nxt       = key_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    res_nxt       = '0;
    cmp_valid_nxt = 1'b0;

    if (srch_start) begin
      issuing_nxt   = 1'b1;
      issue_row_nxt = '0;
      key_nxt       = srch_key;
      used_nxt      = srch_used;
      last_row_nxt  = ROW_W'((srch_used - 1'b1) >> LANE_W);
    end else begin
      if (issuing_r) begin
        cmp_valid_nxt = 1'b1;
        issue_row_nxt = issue_row_r + 1'b1;
        if (issue_row_r == last_row_r) begin
          issuing_nxt = 1'b0;
        end
      end
      if (cmp_valid_r) begin
        if (lane_hit) begin
          res_nxt.done  = 1'b1;
          res_nxt.hit   = 1'b1;
          idx_nxt       = IDX_W'({cmp_row_r, hit_lane});
          issuing_nxt   = 1'b0;
          cmp_valid_nxt = 1'b0;
        end else if (cmp_row_r == last_row_r) begin
          res_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r   <= 1'b0;
      cmp_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      issuing_r   <= issuing_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_row_r <= issue_row_nxt;
    last_row_r  <= last_row_nxt;
    cmp_row_r   <= issue_row_r;
    key_r       <= key_nxt;
    used_r      <= used_nxt;
    idx_r       <= idx_nxt;
  end

  assign srch_res = res_r;
  assign srch_idx = idx_r;

endmodule

// ===== src/lzwc_packer.sv =====
module lzwc_packer import lzwc_pkg::*; #(
  parameter int DICT_SIZE = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pack_ctl_t                              pk_ctl,
  input  logic [$clog2(DICT_SIZE)-1:0]           pk_code,
  input  logic [$clog2($clog2(DICT_SIZE)+1)-1:0] pk_width,
  output logic                                   pk_busy,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [7:0]                             out_tdata,  // out_byte
  output logic                                   out_tlast   // out_last
);

  localparam int CODE_W = $clog2(DICT_SIZE);
  localparam int ACC_W  = PAD_W + CODE_W;
  localparam int BIT_W  = $clog2(ACC_W + 1);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_SHIFT = 2'd1;
  localparam logic [1:0] P_PAD   = 2'd2;

  logic [1:0]       pstate_r, pstate_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [BIT_W-1:0] bits_r, bits_nxt;
  logic             fin_r, fin_nxt;
  logic [PAD_W-1:0] pend_r, pend_nxt;
  logic [2:0]       pend_cnt_r, pend_cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       od_r, od_nxt;
  logic             ol_r, ol_nxt;

  logic             out_free;
  logic [ACC_W-1:0] low_mask;
  logic [PAD_W-1:0] low_bits;
  logic [BIT_W-1:0] bits_left;
  logic [3:0]       pad_sh;

  assign out_free  = !ov_r || out_tready;
  assign low_mask  = (ACC_W'(1) << bits_r) - 1'b1;
  assign low_bits  = PAD_W'(acc_r & low_mask);
  assign bits_left = bits_r - BIT_W'(BYTE_W);
  assign pad_sh    = 4'(BYTE_W) - 4'(bits_r);

  always_comb begin
    pstate_nxt   = pstate_r;
    acc_nxt      = acc_r;
    bits_nxt     = bits_r;
    fin_nxt      = fin_r;
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    ov_nxt       = ov_r && !out_tready;
    od_nxt       = od_r;
    ol_nxt       = ol_r;

    case (pstate_r)
      P_IDLE: begin
        if (pk_ctl.load) begin
          acc_nxt    = (ACC_W'(pend_r) << pk_width) | ACC_W'(pk_code);
          bits_nxt   = BIT_W'(pend_cnt_r) + BIT_W'(pk_width);
          fin_nxt    = pk_ctl.fin;
          pstate_nxt = P_SHIFT;
        end
      end
      P_SHIFT: begin
        if (bits_r >= BIT_W'(BYTE_W)) begin
          if (out_free) begin
            ov_nxt   = 1'b1;
            od_nxt   = 8'(acc_r >> bits_left);
            ol_nxt   = fin_r && (bits_left == '0);
            bits_nxt = bits_left;
          end
        end else if (fin_r && bits_r != '0) begin
          pstate_nxt = P_PAD;
        end else begin
          pend_nxt     = fin_r ? '0 : low_bits;
          pend_cnt_nxt = fin_r ? '0 : 3'(bits_r);
          pstate_nxt   = P_IDLE;
        end
      end
      P_PAD: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          od_nxt       = 8'({1'b0, low_bits} << pad_sh);
          ol_nxt       = 1'b1;
          pend_nxt     = '0;
          pend_cnt_nxt = '0;
          pstate_nxt   = P_IDLE;
        end
      end
      default: pstate_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r   <= P_IDLE;
      pend_r     <= '0;
      pend_cnt_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      pstate_r   <= pstate_nxt;
      pend_r     <= pend_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    bits_r <= bits_nxt;
    fin_r  <= fin_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  assign pk_busy    = pstate_r != P_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

// ===== src/lzw_stream_compressor.sv =====
// LZW byte-stream compressor with variable code width (8 bits up to log2(DICT_SIZE)), codes
// packed MSB first, last output word zero-padded and flagged with out_tlast. The dictionary
// is restarted after every word with in_tlast set. Each input word after the first of a
// stream is looked up, once entries have been added, by a linear scan of the added
// dictionary entries, eight entries per cycle from one wide memory row per read; the scan
// stops at the first hit or after the last used row. A miss, also one with no entries yet,
// passes through S_MISS and S_ADD, and a stream end through S_FIN, where the packer drains
// the previous code. Output words leave the bit packer one per cycle while out_tready is
// high, through a registered output stage; a new code waits until the packer has drained
// the previous one, so out_tready low can hold the input longer.
// No clearing pass is needed after reset.
module lzw_stream_compressor import lzwc_pkg::*; #(
  parameter int DICT_SIZE = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast   // out_last
);

  localparam int CODE_W    = $clog2(DICT_SIZE);
  localparam int KEY_W     = CODE_W + BYTE_W;
  localparam int ADDED_MAX = DICT_SIZE - ROOT_COUNT;
  localparam int IDX_W     = $clog2(ADDED_MAX);
  localparam int CNT_W     = $clog2(DICT_SIZE + 1);
  localparam int WID_W     = $clog2(CODE_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_MISS = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic              have_r, have_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WID_W-1:0]  width_r, width_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;

  logic              srch_start;
  srch_res_t         srch_res;
  logic [IDX_W-1:0]  srch_idx;
  logic              wr_en;
  pack_ctl_t         pk_ctl;
  logic              pk_busy;
  logic              accept;

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;

  lzwc_dict #(.DICT_SIZE(DICT_SIZE)) u_dict (
    .clk        (clk),
    .rst_n      (rst_n),
    .srch_start (srch_start),
    .srch_key   ({prefix_r, in_tdata}),
    .srch_used  ((IDX_W+1)'(count_r - CNT_W'(ROOT_COUNT))),
    .srch_res   (srch_res),
    .srch_idx   (srch_idx),
    .wr_en      (wr_en),
    .wr_idx     (IDX_W'(count_r - CNT_W'(ROOT_COUNT))),
    .wr_key     (KEY_W'({prefix_r, byte_r}))
  );

  lzwc_packer #(.DICT_SIZE(DICT_SIZE)) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .pk_ctl     (pk_ctl),
    .pk_code    (prefix_r),
    .pk_width   (width_r),
    .pk_busy    (pk_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt  = state_r;
    prefix_nxt = prefix_r;
    have_nxt   = have_r;
    count_nxt  = count_r;
    width_nxt  = width_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    srch_start = 1'b0;
    wr_en      = 1'b0;
    pk_ctl     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (!have_r) begin
            prefix_nxt = CODE_W'(in_tdata);
            have_nxt   = 1'b1;
            state_nxt  = in_tlast ? S_FIN : S_IDLE;
          end else if (count_r == CNT_W'(ROOT_COUNT)) begin
            state_nxt = S_MISS;
          end else begin
            srch_start = 1'b1;
            state_nxt  = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (srch_res.done) begin
          if (srch_res.hit) begin
            prefix_nxt = CODE_W'(srch_idx) + CODE_W'(ROOT_COUNT);
            state_nxt  = last_r ? S_FIN : S_IDLE;
          end else begin
            state_nxt = S_MISS;
          end
        end
      end
      S_MISS: begin
        if (!pk_busy) begin
          pk_ctl.load = 1'b1;
          state_nxt   = S_ADD;
        end
      end
      S_ADD: begin
        if (count_r < CNT_W'(DICT_SIZE)) begin
          wr_en = 1'b1;
          if ({1'b0, count_r} >= ((CNT_W+1)'(1) << width_r)) begin
            width_nxt = width_r + 1'b1;
          end
          count_nxt = count_r + 1'b1;
        end
        prefix_nxt = CODE_W'(byte_r);
        state_nxt  = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!pk_busy) begin
          pk_ctl.load = 1'b1;
          pk_ctl.fin  = 1'b1;
          prefix_nxt  = '0;
          have_nxt    = 1'b0;
          count_nxt   = CNT_W'(ROOT_COUNT);
          width_nxt   = WID_W'(START_WIDTH);
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      prefix_r <= '0;
      have_r   <= 1'b0;
      count_r  <= CNT_W'(ROOT_COUNT);
      width_r  <= WID_W'(START_WIDTH);
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      have_r   <= have_nxt;
      count_r  <= count_nxt;
      width_r  <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pk_ctl.load |-> !pk_busy)
    else $error("code handed to busy packer");

  a_done_srch: assert property (@(posedge clk) disable iff (!rst_n)
    srch_res.done |-> state_r == S_SRCH)
    else $error("search result outside search");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(width_r) <= CODE_W) && (32'(count_r) <= DICT_SIZE))
    else $error("code width or entry count out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !pk_busy) |=>
      (count_r == CNT_W'(ROOT_COUNT) && !have_r && pk_busy))
    else $error("stream end did not restart dictionary");

endmodule

// ===== verif/lzw_stream_compressor_tb.sv =====
module lzw_stream_compressor_tb;
  import lzwc_pkg::*;

  localparam int DICT_SIZE   = 4096;
  localparam int ADDED_MAX   = DICT_SIZE - ROOT_COUNT;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_ITEMS  = 90;
  localparam int CALM_ITEMS  = 45;
  localparam int FILL_PASSES = 1;
  localparam int FILL_TAIL   = 20;
  localparam int REPORT_MAX  = 10;
  localparam int ROWS        = 22;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fixed;
    logic [BYTE_W-1:0] fixed_data;
  } row_t;

  typedef enum int {ANY_BYTES, TWO_SYMBOLS, FOUR_SYMBOLS, ONE_RUN} mix_t;

  localparam row_t DIRECTED [ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 8'hFF},
    '{8'hA5, 1'b1, 1'b1, 8'hA5},
    '{8'h5A, 1'b1, 1'b1, 8'h5A},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'hFE, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'hAA, 1'b0, 1'b0, 8'h00},
    '{8'h3C, 1'b1, 1'b0, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'h42, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'h42, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'h42, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;   // in_byte
  logic              in_tlast;   // in_last
  logic              out_tvalid;
  logic              out_tready;
  logic [BYTE_W-1:0] out_tdata;  // out_byte
  logic              out_tlast;  // out_last

  logic [19:0]       pair_tab [ADDED_MAX];
  int unsigned       next_code;
  int unsigned       code_w;
  logic [11:0]       match_code;
  bit                in_stream;
  logic [6:0]        carry_bits;
  int unsigned       carry_cnt;
  word_t             step_words [$];
  word_t             expected_q [$];

  int                sent;
  int                idle_pct;
  int                err_count;
  int                quiet;
  bit                calm;
  bit                hold_go;

  lzw_stream_compressor #(.DICT_SIZE(DICT_SIZE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  function void lzw_restart();
    next_code  = ROOT_COUNT;
    code_w     = START_WIDTH;
    match_code = '0;
    in_stream  = 1'b0;
    carry_bits = '0;
    carry_cnt  = 0;
  endfunction

  function void emit_code(input int unsigned code);
    logic [31:0] acc;
    logic [31:0] tmp;
    int unsigned bits;
    word_t       w;
    acc  = (32'(carry_bits) << code_w) | code;
    bits = carry_cnt + code_w;
    while (bits >= 8) begin
      tmp    = acc >> (bits - 8);
      w.data = tmp[7:0];
      w.last = 1'b0;
      step_words.push_back(w);
      bits -= 8;
    end
    tmp        = acc & ((32'd1 << bits) - 1);
    carry_bits = tmp[6:0];
    carry_cnt  = bits;
  endfunction

  function void lzw_step(input logic [BYTE_W-1:0] b, input logic l);
    logic [19:0] key;
    logic [7:0]  pad;
    int unsigned used;
    bit          found;
    word_t       w;
    step_words.delete();
    found = 1'b0;
    if (!in_stream) begin
      match_code = 12'(b);
      in_stream  = 1'b1;
    end else begin
      key  = {match_code, b};
      used = next_code - ROOT_COUNT;
      for (int unsigned i = 0; i < used && !found; i++) begin
        if (pair_tab[i] == key) begin
          match_code = 12'(ROOT_COUNT + i);
          found      = 1'b1;
        end
      end
      if (!found) begin
        emit_code(match_code);
        if (next_code < DICT_SIZE) begin
          if (next_code >= (32'd1 << code_w)) code_w++;
          pair_tab[next_code - ROOT_COUNT] = key;
          next_code++;
        end
        match_code = 12'(b);
      end
    end
    if (l) begin
      emit_code(match_code);
      if (carry_cnt > 0) begin
        pad    = {1'b0, carry_bits};
        w.data = pad << (8 - carry_cnt);
        w.last = 1'b0;
        step_words.push_back(w);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      lzw_restart();
    end
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic l,
                           input logic fixed, input logic [BYTE_W-1:0] fixed_b);
    int    gap;
    word_t w;
    gap = 0;
    if (!calm && ($urandom_range(0, 99) < idle_pct)) gap = $urandom_range(1, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    lzw_step(b, l);
    if (fixed) begin
      w.data = fixed_b;
      w.last = 1'b1;
      expected_q.push_back(w);
    end else begin
      foreach (step_words[i]) expected_q.push_back(step_words[i]);
    end
    sent++;
  endtask

  task automatic send_stream();
    logic [BYTE_W-1:0] alpha [4];
    logic [BYTE_W-1:0] b;
    mix_t              mix;
    int                len;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    mix      = mix_t'($urandom_range(0, 3));
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
    idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    for (int k = 0; k < len; k++) begin
      case (mix)
        ANY_BYTES:    b = 8'($urandom_range(0, 255));
        TWO_SYMBOLS:  b = alpha[$urandom_range(0, 1)];
        FOUR_SYMBOLS: b = alpha[$urandom_range(0, 3)];
        default: begin
          b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : alpha[0];
        end
      endcase
      send_word(b, k == len - 1, 1'b0, '0);
    end
  endtask

  // walk odd strides so every consecutive pair is new and the code width grows
  task automatic send_fill_stream();
    logic [BYTE_W-1:0] x;
    x        = 8'($urandom_range(0, 255));
    idle_pct = 20;
    send_word(x, 1'b0, 1'b0, '0);
    for (int s = 0; s < FILL_PASSES; s++) begin
      for (int k = 0; k < 256; k++) begin
        x = x + 8'(2 * s + 1);
        send_word(x, 1'b0, 1'b0, '0);
      end
    end
    for (int k = 0; k < FILL_TAIL; k++) begin
      send_word(8'($urandom_range(0, 255)), k == FILL_TAIL - 1, 1'b0, '0);
    end
  endtask

  function void note_error(input string what, input word_t want);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("%s: expected byte %02h last %0b, got byte %02h last %0b",
               what, want.data, want.last, out_tdata, out_tlast);
    end
  endfunction

  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        want = '0;
        note_error("unexpected word", want);
      end else begin
        want = expected_q.pop_front();
        if (want.data !== out_tdata || want.last !== out_tlast) note_error("mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("lzw_stream_compressor_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : drain_side
    int  stall_left;
    int  run_left;
    bit  hold_done;
    out_tready = 1'b0;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_tready <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_tready <= 1'b1;
        run_left = $urandom_range(1, 40) - 1;
      end
    end
  end

  initial begin : feed_side
    int phase_end;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    calm      = 1'b0;
    hold_go   = 1'b0;
    idle_pct  = 30;
    sent      = 0;
    err_count = 0;
    quiet     = 0;
    lzw_restart();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < ROWS; r++) begin
      send_word(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].fixed, DIRECTED[r].fixed_data);
    end

    phase_end = sent + RAND_ITEMS;
    while (sent < phase_end) begin
      if (sent > ROWS + 30) hold_go = 1'b1;
      send_stream();
    end

    send_fill_stream();

    phase_end = sent + RAND_ITEMS;
    while (sent < phase_end) begin
      if (sent >= phase_end - CALM_ITEMS) calm = 1'b1;
      send_stream();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("lzw_stream_compressor_tb passed");
    end else begin
      $display("lzw_stream_compressor_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lzwc_pkg.sv
src/lzwc_dict.sv
src/lzwc_packer.sv
src/lzw_stream_compressor.sv
verif/lzw_stream_compressor_tb.sv
